// ===== hw/rtl/lazy_greedy_set_cover_top_defines.svh =====
// Assertion macros used by the engine top level.
`ifndef LAZY_GREEDY_SET_COVER_TOP_DEFINES_SVH
`define LAZY_GREEDY_SET_COVER_TOP_DEFINES_SVH

// same-cycle implication
`define LGSC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lgsc assertion failed");

// next-cycle implication
`define LGSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lgsc assertion failed");

`endif

// ===== hw/rtl/lgsc_pkg.sv =====
`timescale 1ns / 1ps
package lgsc_pkg;
   localparam int NSETS  = 64;
   localparam int NELEMS = 256;
   localparam int SETW   = $clog2(NSETS);
   localparam int ELW    = $clog2(NELEMS);
   localparam int GAINW  = 9;
   localparam int STAMPW = 16;
   localparam int CHUNK  = 32;
   localparam int NCHUNK = NELEMS / CHUNK;
   localparam int CHW    = $clog2(NCHUNK);

   localparam logic [1:0] CMD_ADD_UNIV = 2'd0;
   localparam logic [1:0] CMD_ADD_SET  = 2'd1;
   localparam logic [1:0] CMD_RUN      = 2'd2;
   localparam logic [1:0] CMD_CLEAR    = 2'd3;

   // candidate handed along the chain
   typedef struct packed {
      logic              valid;
      logic [GAINW-1:0]  gain;
      logic [STAMPW-1:0] stamp;
      logic [SETW-1:0]   idx;
   } cand_type;

   // broadcast update to the cells
   typedef struct packed {
      logic              clr;
      logic              en;
      logic [SETW-1:0]   idx;
      logic [GAINW-1:0]  gain;
      logic [STAMPW-1:0] stamp;
      logic              queued;
   } cell_wr_type;

   function automatic logic [5:0] popcount32(input logic [CHUNK-1:0] x);
      logic [5:0] n;
      n = '0;
      for (int i = 0; i < CHUNK; i++) n = n + {5'd0, x[i]};
      return n;
   endfunction
endpackage

// ===== hw/rtl/lgsc_cell.sv =====
`timescale 1ns / 1ps
module lgsc_cell import lgsc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic [SETW-1:0] my_idx,
   input  cell_wr_type   wr,
   input  cand_type      carry_in,
   output cand_type      carry_out
);
   logic [GAINW-1:0]  gain_ff, gain_in;
   logic [STAMPW-1:0] stamp_ff, stamp_in;
   logic              queued_ff, queued_in;
   cand_type          carry_ff, carry_nx;
   logic              own_ok, own_wins;

   always_comb begin
      gain_in   = gain_ff;
      stamp_in  = stamp_ff;
      queued_in = queued_ff;
      if (wr.clr) begin
         gain_in   = '0;
         stamp_in  = '0;
         queued_in = 1'b0;
      end else if (wr.en && wr.idx == my_idx) begin
         gain_in   = wr.gain;
         stamp_in  = wr.stamp;
         queued_in = wr.queued;
      end
   end

   assign own_ok   = queued_ff && gain_ff != '0;
   assign own_wins = own_ok && (!carry_in.valid || gain_ff > carry_in.gain ||
                     (gain_ff == carry_in.gain && stamp_ff > carry_in.stamp));

   always_comb begin
      carry_nx = carry_in;
      if (own_wins) begin
         carry_nx.valid = 1'b1;
         carry_nx.gain  = gain_ff;
         carry_nx.stamp = stamp_ff;
         carry_nx.idx   = my_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= '0;
         stamp_ff  <= '0;
         queued_ff <= 1'b0;
         carry_ff  <= '0;
      end else begin
         gain_ff   <= gain_in;
         stamp_ff  <= stamp_in;
         queued_ff <= queued_in;
         carry_ff  <= carry_nx;
      end
   end

   assign carry_out = carry_ff;
endmodule

// ===== hw/rtl/lgsc_chain.sv =====
`timescale 1ns / 1ps
module lgsc_chain import lgsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cell_wr_type wr,
   output cand_type    best
);
   cand_type link [NSETS+1];

   assign link[0] = '0;

   for (genvar i = 0; i < NSETS; i++) begin : g_cell
      lgsc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .my_idx    (SETW'(i)),
         .wr        (wr),
         .carry_in  (link[i]),
         .carry_out (link[i+1])
      );
   end

   assign best = link[NSETS];
endmodule

// ===== hw/rtl/lazy_greedy_set_cover_top.sv =====
`timescale 1ns / 1ps
// Lazy greedy set cover engine.
// Input channel req_*: one word per command. Add-universe-element and
// add-element-to-set words are taken one per cycle and give no result.
// Clear-all gives no result. A run word starts a cover
// run; req_ready stays low until the run's last result has been loaded.
// Result channel rsp_*: one word per chosen set in choice order; the final
// word has rsp_last set and rsp_covered_all valid. A run choosing nothing
// gives one word with rsp_found low.
// Run sequence: each loaded set's gain is seeded (row read plus an 8-chunk
// popcount; unloaded sets are skipped), then each examination lets the
// candidate ripple down the 64-cell selection chain and recounts its gain.
// A stalled receiver holds the output register; the engine waits on it.
// Reset (synchronous, high) empties the universe, all sets and the queue.
`include "lazy_greedy_set_cover_top_defines.svh"
module lazy_greedy_set_cover_top import lgsc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [1:0]      req_command,
   input  logic [SETW-1:0] req_set_index,
   input  logic [ELW-1:0]  req_element,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [SETW-1:0] rsp_chosen_set,
   output logic            rsp_found,
   output logic            rsp_covered_all,
   output logic            rsp_last
);
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_INIT   = 4'd1;
   localparam logic [3:0] ST_LOAD   = 4'd2;
   localparam logic [3:0] ST_COUNT  = 4'd3;
   localparam logic [3:0] ST_DECIDE = 4'd4;
   localparam logic [3:0] ST_CHECK  = 4'd5;
   localparam logic [3:0] ST_SWEEP  = 4'd6;
   localparam logic [3:0] ST_EMIT   = 4'd7;
   localparam logic [3:0] ST_FINISH = 4'd8;

   logic [NELEMS-1:0] set_mem [NSETS];
   logic [NELEMS-1:0] row_ff;

   logic [3:0]        state_ff, state_in;
   logic [NELEMS-1:0] universe_ff, universe_in;
   logic [NELEMS-1:0] covered_ff, covered_in;
   logic [NSETS-1:0]  loaded_ff, loaded_in;
   logic [SETW:0]     scan_ff, scan_in;
   logic [SETW-1:0]   sel_ff, sel_in;
   logic [CHW-1:0]    chunk_ff, chunk_in;
   logic [GAINW-1:0]  acc_ff, acc_in;
   logic [GAINW-1:0]  gain_ff, gain_in;
   logic [STAMPW-1:0] stamp_ff, stamp_in;
   logic [SETW+1:0]   sweep_ff, sweep_in;
   logic              init_ff, init_in;
   logic              pend_ff, pend_in;
   logic [SETW-1:0]   pend_idx_ff, pend_idx_in;
   logic              ov_ff, ov_in;
   logic [SETW-1:0]   oset_ff, oset_in;
   logic              ofound_ff, ofound_in, ocov_ff, ocov_in, olast_ff, olast_in;

   cell_wr_type wr;
   cand_type    best;
   logic        req_acc, out_free, univ_done;

   lgsc_chain u_chain (
      .clock (clock),
      .reset (reset),
      .wr    (wr),
      .best  (best)
   );

   assign req_ready   = state_ff == ST_IDLE;
   assign req_acc     = req_valid && req_ready;
   assign out_free    = !ov_ff || rsp_ready;
   assign univ_done   = (universe_ff & ~covered_ff) == '0;

   // set rows: masked write, registered read
   always_ff @(posedge clock) begin
      if (req_acc && req_command == CMD_ADD_SET) begin
         for (int i = 0; i < NELEMS; i++) begin
            if (!loaded_ff[req_set_index] || i == int'(req_element))
               set_mem[req_set_index][i] <= (i == int'(req_element));
         end
      end
      row_ff <= set_mem[sel_ff];
   end

   always_comb begin
      state_in    = state_ff;
      universe_in = universe_ff;
      covered_in  = covered_ff;
      loaded_in   = loaded_ff;
      scan_in     = scan_ff;
      sel_in      = sel_ff;
      chunk_in    = chunk_ff;
      acc_in      = acc_ff;
      gain_in     = gain_ff;
      stamp_in    = stamp_ff;
      sweep_in    = sweep_ff;
      init_in     = init_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      ov_in       = ov_ff && !rsp_ready;
      oset_in     = oset_ff;
      ofound_in   = ofound_ff;
      ocov_in     = ocov_ff;
      olast_in    = olast_ff;
      wr          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               unique case (req_command)
                  CMD_ADD_UNIV: universe_in[req_element] = 1'b1;
                  CMD_ADD_SET:  loaded_in[req_set_index] = 1'b1;
                  CMD_RUN: begin
                     wr.clr     = 1'b1;
                     covered_in = '0;
                     stamp_in   = '0;
                     scan_in    = '0;
                     pend_in    = 1'b0;
                     init_in    = 1'b1;
                     state_in   = ST_INIT;
                  end
                  default: begin
                     universe_in = '0;
                     loaded_in   = '0;
                     covered_in  = '0;
                     wr.clr      = 1'b1;
                  end
               endcase
            end
         end
         ST_INIT: begin
            if (scan_ff == (SETW+1)'(NSETS)) begin
               init_in  = 1'b0;
               state_in = ST_CHECK;
            end else if (loaded_ff[scan_ff[SETW-1:0]]) begin
               sel_in   = scan_ff[SETW-1:0];
               state_in = ST_LOAD;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_LOAD: begin
            chunk_in = '0;
            acc_in   = '0;
            state_in = ST_COUNT;
         end
         ST_COUNT: begin
            acc_in   = acc_ff + GAINW'(popcount32(row_ff[chunk_ff*CHUNK +: CHUNK] &
                       ~covered_ff[chunk_ff*CHUNK +: CHUNK]));
            chunk_in = chunk_ff + 1'b1;
            if (chunk_ff == CHW'(NCHUNK-1)) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            wr.en  = 1'b1;
            wr.idx = sel_ff;
            if (init_ff) begin
               wr.gain   = acc_ff;
               wr.stamp  = stamp_ff;
               wr.queued = 1'b1;
               stamp_in  = stamp_ff + 1'b1;
               scan_in   = scan_ff + 1'b1;
               state_in  = ST_INIT;
            end else if (acc_ff == gain_ff) begin
               // chosen: retire from queue, mark its elements covered
               wr.gain    = gain_ff;
               wr.queued  = 1'b0;
               covered_in = covered_ff | row_ff;
               if (pend_ff) begin
                  state_in = ST_EMIT;
               end else begin
                  pend_in     = 1'b1;
                  pend_idx_in = sel_ff;
                  state_in    = ST_CHECK;
               end
            end else begin
               wr.gain   = acc_ff;
               wr.stamp  = stamp_ff;
               wr.queued = 1'b1;
               stamp_in  = stamp_ff + 1'b1;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            sweep_in = '0;
            state_in = univ_done ? ST_FINISH : ST_SWEEP;
         end
         ST_SWEEP: begin
            // wait for the chain to settle before reading its tail
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == (SETW+2)'(NSETS+1)) begin
               if (!best.valid) begin
                  state_in = ST_FINISH;
               end else begin
                  sel_in   = best.idx;
                  gain_in  = best.gain;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               ov_in       = 1'b1;
               oset_in     = pend_idx_ff;
               ofound_in   = 1'b1;
               ocov_in     = 1'b0;
               olast_in    = 1'b0;
               pend_idx_in = sel_ff;
               state_in    = ST_CHECK;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               ov_in     = 1'b1;
               oset_in   = pend_ff ? pend_idx_ff : '0;
               ofound_in = pend_ff;
               ocov_in   = univ_done;
               olast_in  = 1'b1;
               pend_in   = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         universe_ff <= '0;
         covered_ff  <= '0;
         loaded_ff   <= '0;
         stamp_ff    <= '0;
         init_ff     <= 1'b0;
         pend_ff     <= 1'b0;
         ov_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         universe_ff <= universe_in;
         covered_ff  <= covered_in;
         loaded_ff   <= loaded_in;
         stamp_ff    <= stamp_in;
         init_ff     <= init_in;
         pend_ff     <= pend_in;
         ov_ff       <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      sel_ff      <= sel_in;
      chunk_ff    <= chunk_in;
      acc_ff      <= acc_in;
      gain_ff     <= gain_in;
      sweep_ff    <= sweep_in;
      pend_idx_ff <= pend_idx_in;
      oset_ff     <= oset_in;
      ofound_ff   <= ofound_in;
      ocov_ff     <= ocov_in;
      olast_ff    <= olast_in;
   end

   assign rsp_valid       = ov_ff;
   assign rsp_chosen_set  = oset_ff;
   assign rsp_found       = ofound_ff;
   assign rsp_covered_all = ocov_ff;
   assign rsp_last        = olast_ff;

   `LGSC_ASSERT_IMPL(a_empty_is_last, clock, reset, rsp_valid && !rsp_found, rsp_last)
   `LGSC_ASSERT_IMPL(a_mid_word_clean, clock, reset, rsp_valid && !rsp_last,
      rsp_found && !rsp_covered_all)
   `LGSC_ASSERT_NEXT(a_run_restarts, clock, reset,
      req_acc && req_command == CMD_RUN, stamp_ff == '0 && state_ff == ST_INIT)
   `LGSC_ASSERT_IMPL(a_busy_blocks_req, clock, reset,
      state_ff == ST_SWEEP || state_ff == ST_COUNT, !req_ready)
endmodule
